// ===== hw/rtl/tdms_pkg.sv =====
package tdms_pkg;

  // operation field of an input request
  localparam logic IN_OP_ADD    = 1'b0;
  localparam logic IN_OP_REMOVE = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] dep_mask;
    logic [31:0] task_handle;
    logic [5:0]  slot_id;
  } in_item_t;

  typedef enum logic [2:0] {
    KIND_GRANT = 3'd0,
    KIND_READY = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_FULL  = 3'd3,
    KIND_FREE  = 3'd4
  } res_kind_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [5:0]  slot_out;
    logic [31:0] handle_out;
    logic        last;
  } out_item_t;

  // decoded command handed from the front to the back
  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_REMOVE_BAD = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [63:0] dep_mask;
    logic [31:0] task_handle;
    logic [5:0]  slot_id;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRANT,
    ST_READY,
    ST_PICK,
    ST_EMIT_RDY,
    ST_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/tdms_fifo.sv =====
module tdms_fifo #(
  parameter int DATA_BITS = 8,
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [DATA_BITS-1:0] wr_data,
  output logic                 empty,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]      count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNTW'(do_push) - CNTW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/tdms_front.sv =====
module tdms_front
  import tdms_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     cmd_empty,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam logic [63:0] ROW_MASK = 64'((65'd1 << SLOTS) - 65'd1);
  localparam logic [31:0] HANDLE_MASK = 32'((33'd1 << HW) - 33'd1);

  cmd_t cmd_in;

  // classify the request and drop bits the table cannot hold
  always_comb begin
    cmd_in             = '0;
    cmd_in.dep_mask    = in_item.dep_mask & ROW_MASK;
    cmd_in.task_handle = in_item.task_handle & HANDLE_MASK;
    cmd_in.slot_id     = in_item.slot_id;
    if (in_item.operation == IN_OP_ADD) begin
      cmd_in.op = OP_ADD;
    end else if (7'(in_item.slot_id) >= 7'(SLOTS)) begin
      cmd_in.op = OP_REMOVE_BAD;
    end else begin
      cmd_in.op = OP_REMOVE;
    end
  end

  tdms_fifo #(
    .DATA_BITS($bits(cmd_t)),
    .DEPTH    (2)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .full   (in_full),
    .wr_data(cmd_in),
    .empty  (cmd_empty),
    .pop    (cmd_pop),
    .rd_data(cmd)
  );

endmodule

// ===== hw/rtl/tdms_back.sv =====
module tdms_back
  import tdms_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      res_push,
  input  logic      res_full,
  output out_item_t res
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int NGRP = (SLOTS + 7) / 8;
  localparam int GW = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PADW = NGRP * 8;

  back_state_t state_r, state_nxt;

  logic [SLOTS-1:0] busy_r;
  logic [SLOTS-1:0] rows_r [SLOTS];
  logic [SLOTS-1:0] pend_r;
  logic [CW-1:0]    fc_r;
  logic [CW-1:0]    min_fc_r;
  logic [CW-1:0]    fc_dec;

  logic [SW-1:0]    stk_mem [SLOTS];
  logic [SW-1:0]    stk_rd_r;
  logic [SW-1:0]    stk_idx_r;
  logic             stk_init_r;

  logic [HW-1:0]    hmem [SLOTS];
  logic [HW-1:0]    handle_rd_r;
  logic [HW-1:0]    cur_handle_r;
  logic [SLOTS-1:0] cur_mask_r;
  logic [SW-1:0]    cur_slot_r;
  logic [SW-1:0]    pick_r;

  logic             add_start, rem_start, grant_go, pick_go, h_re;
  logic [SW-1:0]    h_raddr;
  logic [SW-1:0]    cmd_slot;
  logic [SW-1:0]    grant_slot;
  logic [SLOTS-1:0] col_sel;
  logic [SLOTS-1:0] pend_new;

  logic [PADW-1:0]  pend_pad;
  logic [NGRP-1:0]  grp_any;
  logic [GW-1:0]    grp_sel;
  logic [7:0]       grp_bits;
  logic [2:0]       bit_sel;
  logic [SW-1:0]    pick_slot;

  assign fc_dec     = fc_r - 1'b1;
  assign cmd_slot   = cmd.slot_id[SW-1:0];
  assign grant_slot = stk_init_r ? stk_idx_r : stk_rd_r;
  assign col_sel    = SLOTS'(1) << cmd_slot;

  // rows that lose their last dependence when the column is cleared
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      pend_new[j] = (|rows_r[j]) && !(|(rows_r[j] & ~col_sel)) && busy_r[j]
                    && (SW'(j) != cmd_slot);
    end
  end

  // lowest pending row: first nonzero byte, then first bit inside it
  always_comb begin
    pend_pad = PADW'(pend_r);
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |pend_pad[g*8 +: 8];
    end
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GW'(g);
      end
    end
    grp_bits = pend_pad[grp_sel*8 +: 8];
    bit_sel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 3'(b);
      end
    end
    pick_slot = SW'({grp_sel, bit_sel});
  end

  // outputs and strobes
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    add_start = 1'b0;
    rem_start = 1'b0;
    grant_go  = 1'b0;
    pick_go   = 1'b0;
    h_re      = 1'b0;
    h_raddr   = cur_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_ADD: begin
              if (fc_r != '0) begin
                cmd_pop   = 1'b1;
                add_start = 1'b1;
              end else if (!res_full) begin
                cmd_pop       = 1'b1;
                res_push      = 1'b1;
                res.kind      = KIND_FULL;
                res.last      = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (busy_r[cmd_slot]) begin
                cmd_pop   = 1'b1;
                rem_start = 1'b1;
              end else if (!res_full) begin
                cmd_pop      = 1'b1;
                res_push     = 1'b1;
                res.kind     = KIND_FREE;
                res.slot_out = cmd.slot_id;
                res.last     = 1'b1;
              end
            end
            default: begin
              if (!res_full) begin
                cmd_pop      = 1'b1;
                res_push     = 1'b1;
                res.kind     = KIND_FREE;
                res.slot_out = cmd.slot_id;
                res.last     = 1'b1;
              end
            end
          endcase
        end
      end
      ST_GRANT: begin
        if (!res_full) begin
          grant_go       = 1'b1;
          res_push       = 1'b1;
          res.kind       = KIND_GRANT;
          res.slot_out   = 6'(grant_slot);
          res.handle_out = 32'(cur_handle_r);
          res.last       = (cur_mask_r == '0);
        end
      end
      ST_READY: begin
        if (!res_full) begin
          res_push       = 1'b1;
          res.kind       = KIND_READY;
          res.slot_out   = 6'(cur_slot_r);
          res.handle_out = 32'(cur_handle_r);
          res.last       = 1'b1;
        end
      end
      ST_PICK: begin
        h_re = 1'b1;
        if (pend_r != '0) begin
          pick_go = 1'b1;
          h_raddr = pick_slot;
        end
      end
      ST_EMIT_RDY: begin
        if (!res_full) begin
          res_push       = 1'b1;
          res.kind       = KIND_READY;
          res.slot_out   = 6'(pick_r);
          res.handle_out = 32'(handle_rd_r);
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push       = 1'b1;
          res.kind       = KIND_DONE;
          res.slot_out   = 6'(cur_slot_r);
          res.handle_out = 32'(handle_rd_r);
          res.last       = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (add_start) begin
          state_nxt = ST_GRANT;
        end else if (rem_start) begin
          state_nxt = ST_PICK;
        end
      end
      ST_GRANT: begin
        if (!res_full) begin
          state_nxt = (cur_mask_r == '0) ? ST_READY : ST_IDLE;
        end
      end
      ST_READY: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PICK: begin
        state_nxt = (pend_r != '0) ? ST_EMIT_RDY : ST_DONE;
      end
      ST_EMIT_RDY: begin
        if (!res_full) begin
          state_nxt = ST_PICK;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= '0;
      pend_r   <= '0;
      fc_r     <= CW'(SLOTS);
      min_fc_r <= CW'(SLOTS);
    end else begin
      state_r <= state_nxt;
      if (add_start) begin
        fc_r <= fc_dec;
        if (fc_dec < min_fc_r) begin
          min_fc_r <= fc_dec;
        end
      end else if (rem_start && (fc_r < CW'(SLOTS))) begin
        fc_r <= fc_r + 1'b1;
      end
      if (grant_go) begin
        busy_r[grant_slot] <= 1'b1;
      end else if (rem_start) begin
        busy_r[cmd_slot] <= 1'b0;
      end
      if (rem_start) begin
        pend_r <= pend_new;
      end else if (pick_go) begin
        pend_r[pick_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_start) begin
      cur_mask_r   <= cmd.dep_mask[SLOTS-1:0];
      cur_handle_r <= cmd.task_handle[HW-1:0];
      stk_idx_r    <= fc_dec[SW-1:0];
      // entries below the lowest fill level ever reached were never written; the index itself is the free slot
      stk_init_r   <= (fc_dec < min_fc_r);
    end
    if (grant_go) begin
      cur_slot_r <= grant_slot;
    end else if (rem_start) begin
      cur_slot_r <= cmd_slot;
    end
    if (pick_go) begin
      pick_r <= pick_slot;
    end
    for (int j = 0; j < SLOTS; j++) begin
      if (rem_start) begin
        rows_r[j] <= (SW'(j) == cmd_slot) ? '0 : (rows_r[j] & ~col_sel);
      end else if (grant_go && (SW'(j) == grant_slot)) begin
        rows_r[j] <= cur_mask_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rem_start && (fc_r < CW'(SLOTS))) begin
      stk_mem[fc_r[SW-1:0]] <= cmd_slot;
    end
    if (add_start) begin
      stk_rd_r <= stk_mem[fc_dec[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (grant_go) begin
      hmem[grant_slot] <= cur_handle_r;
    end
    if (h_re) begin
      handle_rd_r <= hmem[h_raddr];
    end
  end

`ifndef SYNTHESIS
  a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(SLOTS))
    else $error("free count above slot count");

  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(busy_r) + int'(fc_r) == SLOTS))
    else $error("busy slots and free count disagree");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pend_r == '0))
    else $error("ready rows left pending at idle");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result pushed into full queue");

  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT) |-> !busy_r[grant_slot])
    else $error("granted slot already busy");
`endif

endmodule

// ===== hw/rtl/task_dependence_matrix_scheduler_top.sv =====
// task dependence matrix scheduler
// requests enter through a queue-style port: drive in_item and raise in_push;
// the request is taken on a clock edge where in_full is low. an add grants a
// slot (highest free slot first after reset) and, with an empty mask, reports
// it ready; a remove frees the slot, reports each row whose last dependence it
// cleared as ready in ascending slot order, then a done item.
// results leave through out_item while out_empty is low and are taken on an
// edge where out_pop is high; last marks the final result of a request, except
// on a grant, where last is set when the mask is empty and a ready follows,
// and clear when the grant is the final result. the execution unit works on one
// request at a time and pops the next command only when it is back in idle.
// the ready rows are found by a two-level priority pick over the pending
// bitmap and each needs one read of the handle memory, which sets the pace.
// a two-entry command queue and a two-entry result queue decouple both sides;
// when out_pop stays low the unit stops at its next result and the command
// queue fills, then in_full rises.
// reset (synchronous, rst_n low) frees every slot at once; no clearing pass.
module task_dependence_matrix_scheduler_top
  import tdms_pkg::*;
#(
  parameter int SLOTS = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic      cmd_empty, cmd_pop;
  cmd_t      cmd;
  logic      res_push, res_full;
  out_item_t res;

  tdms_front #(
    .SLOTS      (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  tdms_back #(
    .SLOTS      (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res)
  );

  tdms_fifo #(
    .DATA_BITS($bits(out_item_t)),
    .DEPTH    (2)
  ) u_res_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .full   (res_full),
    .wr_data(res),
    .empty  (out_empty),
    .pop    (out_pop),
    .rd_data(out_item)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import tdms_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_REQUESTS = 210;
  localparam int CYCLE_LIMIT = 400000;

  class sched_scoreboard;
    out_item_t   pending_results[$];
    logic [63:0] dep_rows[SLOTS];
    logic [5:0]  free_stack[SLOTS];
    int          free_count;
    bit          slot_busy[SLOTS];
    logic [31:0] handles[SLOTS];
    int          errors;
    int          requests;
    int          results;
    int          ready_seen;
    int          full_seen;
    int          free_seen;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        dep_rows[i] = '0;
        free_stack[i] = 6'(i);
        slot_busy[i] = 1'b0;
        handles[i] = '0;
      end
      free_count = SLOTS;
      errors = 0;
      requests = 0;
      results = 0;
      ready_seen = 0;
      full_seen = 0;
      free_seen = 0;
    endfunction

    function void queue_result(res_kind_t k, int slot, logic [31:0] h, logic last);
      out_item_t r;
      r.kind = k;
      r.slot_out = 6'(slot);
      r.handle_out = h;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void note_request(in_item_t req);
      int s;
      int n;
      logic [63:0] prev;
      logic [63:0] now;
      requests++;
      if (req.operation == IN_OP_ADD) begin
        if (free_count == 0) begin
          queue_result(KIND_FULL, 0, '0, 1'b1);
          return;
        end
        free_count--;
        s = int'(free_stack[free_count]);
        dep_rows[s] = req.dep_mask;
        handles[s] = req.task_handle;
        slot_busy[s] = 1'b1;
        queue_result(KIND_GRANT, s, req.task_handle, req.dep_mask == '0);
        if (req.dep_mask == '0) queue_result(KIND_READY, s, req.task_handle, 1'b1);
      end else begin
        s = int'(req.slot_id);
        if (s >= SLOTS || !slot_busy[s]) begin
          queue_result(KIND_FREE, s, '0, 1'b1);
          return;
        end
        slot_busy[s] = 1'b0;
        if (free_count < SLOTS) begin
          free_stack[free_count] = 6'(s);
          free_count++;
        end
        dep_rows[s] = '0;
        n = 0;
        // column clear, rows that lose their last dependence become ready
        for (int j = 0; j < SLOTS; j++) begin
          prev = dep_rows[j];
          now = prev & ~(64'd1 << s);
          dep_rows[j] = now;
          if (prev != '0 && now == '0 && slot_busy[j] && n < SLOTS - 1) begin
            queue_result(KIND_READY, j, handles[j], 1'b0);
            n++;
          end
        end
        queue_result(KIND_DONE, s, handles[s], 1'b1);
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("error at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (got.kind == KIND_READY) ready_seen++;
      if (got.kind == KIND_FULL) full_seen++;
      if (got.kind == KIND_FREE) free_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d slot %0d handle %h last %0d",
                         got.kind, got.slot_out, got.handle_out, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.slot_out !== want.slot_out ||
          got.handle_out !== want.handle_out || got.last !== want.last)
        report($sformatf("expected kind %0d slot %0d handle %h last %0d, got kind %0d slot %0d handle %h last %0d",
                         want.kind, want.slot_out, want.handle_out, want.last,
                         got.kind, got.slot_out, got.handle_out, got.last));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  sched_scoreboard sb;
  int cycles;
  int in_calm;
  int out_calm;

  task_dependence_matrix_scheduler_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("task_dependence_matrix_scheduler_top: mismatch");
        $finish;
      end
    end
  end

  // random gaps, with occasional stretches where the side never idles
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic in_item_t make_request(logic op, logic [63:0] mask,
                                            logic [31:0] handle, logic [5:0] sid);
    in_item_t req;
    req.operation = op;
    req.dep_mask = mask;
    req.task_handle = handle;
    req.slot_id = sid;
    return req;
  endfunction

  function automatic in_item_t random_request(int add_pct);
    in_item_t req;
    int busy_list[$];
    int pick;
    req.dep_mask = {$urandom, $urandom};
    req.task_handle = $urandom;
    req.slot_id = 6'($urandom);
    req.operation = ($urandom_range(0, 99) < add_pct) ? IN_OP_ADD : IN_OP_REMOVE;
    for (int j = 0; j < SLOTS; j++)
      if (sb.slot_busy[j]) busy_list.push_back(j);
    if (req.operation == IN_OP_ADD) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        req.dep_mask = '0;
      end else if (pick >= 25) begin
        // wait on a few live tasks, now and then on a free slot too
        req.dep_mask = '0;
        foreach (busy_list[k])
          if ($urandom_range(0, 5) == 0) req.dep_mask[busy_list[k]] = 1'b1;
        if ($urandom_range(0, 9) == 0) req.dep_mask[$urandom_range(0, 63)] = 1'b1;
      end
    end else if (busy_list.size() > 0 && $urandom_range(0, 99) < 85) begin
      req.slot_id = 6'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
    end
    return req;
  endfunction

  task automatic push_request(in_item_t req);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= req;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_request(req);
  endtask

  task automatic drain_results();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int gap;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_result(out_item);
    end
  end

  initial begin
    int top;
    int add_pct;
    sb = new();
    in_calm = 0;
    out_calm = 0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty mask, full mask, handle extremes
    push_request(make_request(IN_OP_ADD, 64'd0, 32'h0000_0000, 6'd0));
    push_request(make_request(IN_OP_ADD, {64{1'b1}}, 32'hffff_ffff, 6'h3f));
    push_request(make_request(IN_OP_ADD, 64'h8000_0000_0000_0000, 32'h5a5a_a5a5, 6'd0));
    push_request(make_request(IN_OP_ADD, 64'ha000_0000_0000_0000, 32'h1234_5678, 6'd0));
    // removing a free slot at the lowest id, busy slots, and a slot already freed
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'd0));
    push_request(make_request(IN_OP_REMOVE, {64{1'b1}}, 32'hffff_ffff, 6'd63));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'd63));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'd61));
    // task that waits on its own slot
    top = int'(sb.free_stack[sb.free_count - 1]);
    push_request(make_request(IN_OP_ADD, 64'd1 << top, 32'hdead_beef, 6'd0));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'(top)));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'd62));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'd60));
    // dependence on a slot that is free
    top = int'(sb.free_stack[sb.free_count - 1]);
    push_request(make_request(IN_OP_ADD, 64'd1, 32'h0000_0001, 6'd0));
    push_request(make_request(IN_OP_REMOVE, 64'd0, 32'd0, 6'(top)));
    push_request(make_request(IN_OP_ADD, 64'd1 << 63, 32'h8000_0000, 6'd0));

    // mixed, then fill past full, then mostly drain
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 80 || i == 160) begin
        in_push <= 1'b0;
        drain_results();
      end
      add_pct = (i < 80) ? 55 : (i < 160) ? 95 : 15;
      push_request(random_request(add_pct));
    end
    in_push <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests and %0d results: %0d ready, %0d table full, %0d free slot",
             sb.requests, sb.results, sb.ready_seen, sb.full_seen, sb.free_seen);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("task_dependence_matrix_scheduler_top: match");
    end else begin
      $display("%0d errors, %0d results still expected", sb.errors,
               sb.pending_results.size());
      $display("task_dependence_matrix_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule
